FILE: rtl/fcp_pkg.sv
// Shared types, codes and helpers for the FIFO-replacement cache tag model.
// No dependencies; imported by fcp_way_match and the top level.
`default_nettype none

package fcp_pkg;

  // Access kind carried on the input side band
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_SET_BITS   = 2'd0,
    CFG_BLOCK_BITS = 2'd1,
    CFG_WAYS       = 2'd2,
    CFG_PREFETCH   = 2'd3
  } cfg_index_t;

  localparam int CFG_W = 4;

  localparam logic [CFG_W-1:0] SET_BITS_RST   = 4'd6;
  localparam logic [CFG_W-1:0] BLOCK_BITS_RST = 4'd4;
  localparam logic [CFG_W-1:0] WAYS_RST       = 4'd1;
  localparam logic             PREFETCH_RST   = 1'b0;

  localparam logic [CFG_W-1:0] MAX_BLOCK_BITS = 4'd12;

  localparam int CNT_W = 32;
  localparam int OUT_W = 136;

  // Status of one set lookup
  typedef struct packed {
    logic hit;
    logic fifo_adv;
  } match_status_t;

  // Add a small increment to a running total, stopping at all ones
  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] total,
                                               input logic [1:0] inc);
    logic [CNT_W:0] sum;
    sum = {1'b0, total} + (CNT_W+1)'(inc);
    return sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/fcp_tag_ram.sv
// Single-port-write, single-port-read tag row memory with registered read data.
// Holds one row (tags, valid bits, FIFO pointer) per set; no dependencies.
`default_nettype none

module fcp_tag_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 395,
  parameter int AW    = 8
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/fcp_way_match.sv
// Tag compare and FIFO victim selection over one set row.
// Depends on fcp_pkg for the lookup status struct.
`default_nettype none

module fcp_way_match #(
  parameter int MAX_WAYS  = 8,
  parameter int ADDR_BITS = 48,
  localparam int WI_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
  localparam int WAYS_W   = $clog2(MAX_WAYS + 1)
) (
  input  wire logic [MAX_WAYS-1:0][ADDR_BITS-1:0] tags,
  input  wire logic [MAX_WAYS-1:0]                valid,
  input  wire logic [WI_W-1:0]                    oldest,
  input  wire logic [ADDR_BITS-1:0]               tag,
  input  wire logic [WAYS_W-1:0]                  ways,
  output fcp_pkg::match_status_t                  status,
  output logic      [MAX_WAYS-1:0][ADDR_BITS-1:0] new_tags,
  output logic      [MAX_WAYS-1:0]                new_valid,
  output logic      [WI_W-1:0]                    new_oldest
);

  import fcp_pkg::*;

  logic            hit;
  logic            free_found;
  logic [WI_W-1:0] free_idx;
  logic [WI_W-1:0] old_sel;
  logic [WI_W-1:0] victim;
  logic [WI_W-1:0] old_succ;
  logic            adv;

  always_comb begin
    hit        = 1'b0;
    free_found = 1'b0;
    free_idx   = '0;
    // Walk downwards so the lowest free way wins
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (WAYS_W'(w) < ways) begin
        if (valid[w] && (tags[w] == tag)) begin
          hit = 1'b1;
        end
        if (!valid[w]) begin
          free_found = 1'b1;
          free_idx   = WI_W'(w);
        end
      end
    end

    // A pointer left beyond the ways in use falls back to way 0
    old_sel  = (WAYS_W'(oldest) >= ways) ? '0 : oldest;
    old_succ = ((WAYS_W'(old_sel) + WAYS_W'(1)) == ways) ? '0 : WI_W'(old_sel + 1'b1);
    victim   = free_found ? free_idx : old_sel;
    adv      = !hit && !free_found;

    new_tags   = tags;
    new_valid  = valid;
    new_oldest = adv ? old_succ : oldest;
    if (!hit) begin
      new_tags[victim]  = tag;
      new_valid[victim] = 1'b1;
    end

    status.hit      = hit;
    status.fifo_adv = adv;
  end

endmodule

`default_nettype wire

FILE: rtl/fifo_cache_with_next_line_prefetch_top.sv
// Top level of the write-through set-associative cache tag model with FIFO
// replacement and next-line prefetch. Uses fcp_pkg, fcp_tag_ram, fcp_way_match.
`default_nettype none

// Each access (read or write, with a byte address) is looked up in a tag RAM
// that holds one row per set: every way's tag, the valid bits and the set's
// FIFO pointer. An access has an accept step, which issues the row read, and a
// compare step, which matches the tag, picks a victim and writes the row back
// on a miss. With prefetch enabled a demand miss adds a second lookup of the
// next block through the same RAM read port and the same compare unit. A new
// access is accepted only when the sequencer is back in idle, once the last
// one and any held result are out. A result waits in the output register;
// if it is still held when the next one is ready, the block holds that one
// until the output frees. Every result carries the saturating running totals
// after the access. After reset no clearing pass is needed: a flag per set,
// cleared by reset, marks rows never written, which read as empty with the
// FIFO pointer at way 0. Write configuration only while no access is in
// flight; entries are kept across a change and compared with the new split.
module fifo_cache_with_next_line_prefetch_top #(
  parameter int MAX_SETS  = 256,
  parameter int MAX_WAYS  = 8,
  parameter int ADDR_BITS = 48
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // configuration write port
  input  wire logic                                cfg_we,
  input  wire fcp_pkg::cfg_index_t                 cfg_index,
  input  wire logic [fcp_pkg::CFG_W-1:0]           cfg_data,
  // access stream
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [((ADDR_BITS + 7) / 8) * 8-1:0] s_tdata, // address
  input  wire logic                                s_tuser, // command
  // result stream
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  // hit, reads_caused[2], write_caused, total_reads[32], total_writes[32],
  // total_hits[32], total_misses[32], zero pad[4]
  output logic [fcp_pkg::OUT_W-1:0]                m_tdata
);

  import fcp_pkg::*;

  localparam int WI_W         = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WAYS_W       = $clog2(MAX_WAYS + 1);
  localparam int SET_AW       = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int SET_BITS_MAX = $clog2(MAX_SETS + 1) - 1;
  localparam int TAGS_W       = MAX_WAYS * ADDR_BITS;
  localparam int ROW_W        = TAGS_W + MAX_WAYS + WI_W;
  localparam int SH_W         = 5;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_PF,
    S_HOLD
  } state_t;

  state_t state;

  // configuration
  logic [CFG_W-1:0] set_bits_r;
  logic [CFG_W-1:0] block_bits_r;
  logic [CFG_W-1:0] ways_r;
  logic             pf_en_r;

  logic [CFG_W-1:0]  s_eff;
  logic [CFG_W-1:0]  b_eff;
  logic [WAYS_W-1:0] ways_eff;
  logic [SH_W-1:0]   sh_amt;

  // access in flight
  logic                 cmd_q;
  logic [ADDR_BITS-1:0] addr_q;
  logic [SET_AW-1:0]    set_q;
  logic [SET_AW-1:0]    set_p_q;
  logic [ADDR_BITS-1:0] tag_p_q;
  logic                 fwd_q;
  logic [ROW_W-1:0]     wr_row_q;
  logic                 rd_init_q;
  logic [OUT_W-1:0]     pend_q;

  logic [MAX_SETS-1:0]  row_init;

  // totals
  logic [CNT_W-1:0] read_total;
  logic [CNT_W-1:0] write_total;
  logic [CNT_W-1:0] hit_total;
  logic [CNT_W-1:0] miss_total;
  logic [CNT_W-1:0] read_total_next;
  logic [CNT_W-1:0] write_total_next;
  logic [CNT_W-1:0] hit_total_next;
  logic [CNT_W-1:0] miss_total_next;

  logic                 accept;
  logic                 out_free;
  logic [ADDR_BITS-1:0] in_addr;
  logic [SET_AW-1:0]    in_set;
  logic [ADDR_BITS-1:0] tag_d;
  logic [ADDR_BITS-1:0] nxt_addr;
  logic [SET_AW-1:0]    set_p;
  logic [ADDR_BITS-1:0] tag_p;
  logic                 pf_go;
  logic                 fin;
  logic                 res_hit;
  logic [1:0]           res_reads;
  logic                 res_write;
  logic [OUT_W-1:0]     res_word;

  // RAM side
  logic              ram_we;
  logic [SET_AW-1:0] ram_waddr;
  logic [ROW_W-1:0]  ram_wdata;
  logic              ram_re;
  logic [SET_AW-1:0] ram_raddr;
  logic [ROW_W-1:0]  ram_rdata;
  logic [ROW_W-1:0]  row_sel;
  logic              row_init_sel;

  // compare unit
  logic [MAX_WAYS-1:0][ADDR_BITS-1:0] m_tags;
  logic [MAX_WAYS-1:0]                m_valid;
  logic [WI_W-1:0]                    m_oldest;
  logic [ADDR_BITS-1:0]               m_tag;
  match_status_t                      ms;
  logic [MAX_WAYS-1:0][ADDR_BITS-1:0] n_tags;
  logic [MAX_WAYS-1:0]                n_valid;
  logic [WI_W-1:0]                    n_oldest;

  // Set index of an address under the current split
  function automatic logic [SET_AW-1:0] set_of(input logic [ADDR_BITS-1:0] a,
                                               input logic [CFG_W-1:0] b,
                                               input logic [CFG_W-1:0] s);
    logic [ADDR_BITS-1:0] shifted;
    logic [SET_AW-1:0]    msk;
    shifted = a >> b;
    msk     = ~({SET_AW{1'b1}} << s);
    return shifted[SET_AW-1:0] & msk;
  endfunction

  // Clamp the configuration to what the store supports
  always_comb begin
    s_eff = (32'(set_bits_r) > SET_BITS_MAX) ? CFG_W'(SET_BITS_MAX) : set_bits_r;
    b_eff = (block_bits_r > MAX_BLOCK_BITS) ? MAX_BLOCK_BITS : block_bits_r;
    if (ways_r == '0) begin
      ways_eff = WAYS_W'(1);
    end else if (32'(ways_r) > MAX_WAYS) begin
      ways_eff = WAYS_W'(MAX_WAYS);
    end else begin
      ways_eff = WAYS_W'(ways_r);
    end
    sh_amt = SH_W'(b_eff) + SH_W'(s_eff);
  end

  always_comb begin
    accept   = s_tvalid && s_tready;
    out_free = !m_tvalid || m_tready;
    in_addr  = s_tdata[ADDR_BITS-1:0];
    in_set   = set_of(in_addr, b_eff, s_eff);

    tag_d    = addr_q >> sh_amt;
    // next block wraps within the address width
    nxt_addr = addr_q + (ADDR_BITS'(1) << b_eff);
    set_p    = set_of(nxt_addr, b_eff, s_eff);
    tag_p    = nxt_addr >> sh_amt;

    // Forward the row just written when the prefetch lands in the same set
    if (state == S_PF && fwd_q) begin
      row_sel      = wr_row_q;
      row_init_sel = 1'b1;
    end else begin
      row_sel      = ram_rdata;
      row_init_sel = rd_init_q;
    end
    m_tags   = row_sel[TAGS_W-1:0];
    m_valid  = row_init_sel ? row_sel[TAGS_W +: MAX_WAYS] : '0;
    m_oldest = row_init_sel ? row_sel[TAGS_W + MAX_WAYS +: WI_W] : '0;
    m_tag    = (state == S_PF) ? tag_p_q : tag_d;

    pf_go     = (state == S_CMP) && !ms.hit && pf_en_r;
    ram_re    = accept || pf_go;
    ram_raddr = (state == S_IDLE) ? in_set : set_p;
    ram_we    = ((state == S_CMP) || (state == S_PF)) && !ms.hit;
    ram_waddr = (state == S_PF) ? set_p_q : set_q;
    ram_wdata = {n_oldest, n_valid, n_tags};

    fin       = ((state == S_CMP) && !pf_go) || (state == S_PF);
    res_hit   = (state == S_CMP) && ms.hit;
    res_write = (cmd_q == CMD_WRITE);
    if (state == S_CMP) begin
      res_reads = ms.hit ? 2'd0 : 2'd1;
    end else begin
      res_reads = ms.hit ? 2'd1 : 2'd2;
    end

    read_total_next  = sat_add(read_total, res_reads);
    write_total_next = sat_add(write_total, {1'b0, res_write});
    hit_total_next   = sat_add(hit_total, {1'b0, res_hit});
    miss_total_next  = sat_add(miss_total, {1'b0, !res_hit});

    res_word = {4'b0000, miss_total_next, hit_total_next, write_total_next,
                read_total_next, res_write, res_reads, res_hit};
    s_tready = (state == S_IDLE);
  end

  fcp_tag_ram #(
    .DEPTH (MAX_SETS),
    .WIDTH (ROW_W),
    .AW    (SET_AW)
  ) u_tag_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  fcp_way_match #(
    .MAX_WAYS  (MAX_WAYS),
    .ADDR_BITS (ADDR_BITS)
  ) u_way_match (
    .tags       (m_tags),
    .valid      (m_valid),
    .oldest     (m_oldest),
    .tag        (m_tag),
    .ways       (ways_eff),
    .status     (ms),
    .new_tags   (n_tags),
    .new_valid  (n_valid),
    .new_oldest (n_oldest)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits_r   <= SET_BITS_RST;
      block_bits_r <= BLOCK_BITS_RST;
      ways_r       <= WAYS_RST;
      pf_en_r      <= PREFETCH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SET_BITS:   set_bits_r   <= cfg_data;
        CFG_BLOCK_BITS: block_bits_r <= cfg_data;
        CFG_WAYS:       ways_r       <= cfg_data;
        CFG_PREFETCH:   pf_en_r      <= cfg_data[0];
        default:        ;
      endcase
    end
  end

  // Row written flags: a row never written reads as empty
  always_ff @(posedge clk) begin
    if (rst) begin
      row_init <= '0;
    end else if (ram_we) begin
      row_init[ram_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      rd_init_q <= row_init[ram_raddr];
    end
  end

  // Hold the access and the prefetch lookup details
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q  <= s_tuser;
      addr_q <= in_addr;
      set_q  <= in_set;
    end
    if (state == S_CMP) begin
      set_p_q  <= set_p;
      tag_p_q  <= tag_p;
      fwd_q    <= (set_p == set_q);
      wr_row_q <= ram_wdata;
    end
  end

  // Running totals advance once per access
  always_ff @(posedge clk) begin
    if (rst) begin
      read_total  <= '0;
      write_total <= '0;
      hit_total   <= '0;
      miss_total  <= '0;
    end else if (fin) begin
      read_total  <= read_total_next;
      write_total <= write_total_next;
      hit_total   <= hit_total_next;
      miss_total  <= miss_total_next;
    end
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (pf_go) begin
            state <= S_PF;
          end else if (out_free) begin
            state <= S_IDLE;
          end else begin
            state <= S_HOLD;
          end
        end
        S_PF: begin
          state <= out_free ? S_IDLE : S_HOLD;
        end
        S_HOLD: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      if (fin && out_free) begin
        m_tvalid <= 1'b1;
        m_tdata  <= res_word;
      end else if ((state == S_HOLD) && out_free) begin
        m_tvalid <= 1'b1;
        m_tdata  <= pend_q;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      if (fin && !out_free) begin
        pend_q <= res_word;
      end
    end
  end

  // A held result only exists while the output register is occupied
  a_hold_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_HOLD) |-> m_tvalid)
    else $error("result held while output register empty");

  // Forwarding is only used when the prefetch set matches the demand set
  a_fwd_set: assert property (@(posedge clk) disable iff (rst)
    ((state == S_PF) && fwd_q) |-> (set_p_q == set_q))
    else $error("prefetch forwarding across different sets");

  // A row write always marks the row as written
  a_row_init: assert property (@(posedge clk) disable iff (rst)
    ram_we |=> row_init[$past(ram_waddr)])
    else $error("row written but not flagged");

  // Totals move only at the end of an access
  a_totals_hold: assert property (@(posedge clk) disable iff (rst)
    !fin |=> ($stable(hit_total) && $stable(miss_total)))
    else $error("totals changed outside access completion");

  // A hit never moves the FIFO pointer
  a_hit_no_adv: assert property (@(posedge clk) disable iff (rst)
    (((state == S_CMP) || (state == S_PF)) && ms.hit) |-> !ms.fifo_adv)
    else $error("FIFO pointer advanced on a hit");

endmodule

`default_nettype wire
